// ===== rtl/assert_macros.svh =====
// Assertion macros for the execute unit checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define VCPU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define VCPU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/vcpu_pkg.sv =====
// Shared types and constants for the virtual CPU execute unit.
// No dependencies.
`default_nettype none

package vcpu_pkg;

	typedef enum logic [1:0] {
		REQ_EXEC  = 2'd0,
		REQ_KEY   = 2'd1,
		REQ_MEMWR = 2'd2,
		REQ_FBRD  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_UNF = 2'd2,
		ST_BAD = 2'd3
	} status_t;

	// How the controller sequences an executed opcode
	typedef enum logic [2:0] {
		CLS_ONE,
		CLS_ALUF,
		CLS_DRAW,
		CLS_BCD,
		CLS_STORE,
		CLS_LOAD
	} op_class_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_EXEC,
		S_ALUX,
		S_SPR_RAM,
		S_SPR_FB,
		S_SPR_W0,
		S_SPR_W1,
		S_SPR_VF,
		S_BCD,
		S_ST_RD,
		S_ST_WR,
		S_LD_RD,
		S_LD_WR,
		S_FBRD,
		S_DONE
	} state_t;

	localparam int SCREEN_ROWS = 32;
	localparam int ROW_W       = $clog2(SCREEN_ROWS);
	localparam int FB_BYTES    = SCREEN_ROWS * 8;
	localparam int FB_AW       = $clog2(FB_BYTES);

	localparam logic [11:0] PC_RESET   = 12'h200;
	localparam logic [11:0] FONT_RESET = 12'd80;

	// opcode groups (top nibble)
	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SE   = 4'h3;
	localparam logic [3:0] GRP_SNE  = 4'h4;
	localparam logic [3:0] GRP_SER  = 4'h5;
	localparam logic [3:0] GRP_LD   = 4'h6;
	localparam logic [3:0] GRP_ADD  = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SNER = 4'h9;
	localparam logic [3:0] GRP_LDI  = 4'hA;
	localparam logic [3:0] GRP_JPV  = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_DRW  = 4'hD;
	localparam logic [3:0] GRP_KEY  = 4'hE;
	localparam logic [3:0] GRP_MISC = 4'hF;

	// ALU group low nibble
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [7:0] KEY_SKP  = 8'h9E;
	localparam logic [7:0] KEY_SKNP = 8'hA1;

	localparam logic [7:0] F_GETDT = 8'h07;
	localparam logic [7:0] F_SETDT = 8'h15;
	localparam logic [7:0] F_SETST = 8'h18;
	localparam logic [7:0] F_ADDI  = 8'h1E;
	localparam logic [7:0] F_FONT  = 8'h29;
	localparam logic [7:0] F_BCD   = 8'h33;
	localparam logic [7:0] F_STORE = 8'h55;
	localparam logic [7:0] F_LOAD  = 8'h65;

	typedef struct packed {
		logic accept;
		logic dispatch;
		logic exec;
		logic alu_wx;
		logic spr_ram;
		logic spr_fb;
		logic spr_w0;
		logic spr_w1;
		logic spr_vf;
		logic bcd_wr;
		logic st_rd;
		logic st_wr;
		logic ld_rd;
		logic ld_wr;
		logic fb_done;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		req_t      req;
		op_class_t cls;
		logic      n_zero;
		logic      last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/vcpu_ctrl.sv =====
// Sequencer for the execute unit: one state per datapath step.
// Depends on vcpu_pkg.
`default_nettype none

module vcpu_ctrl import vcpu_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_DISP;
			S_DISP: begin
				case (sts.req)
					REQ_EXEC: state_d = S_EXEC;
					REQ_FBRD: state_d = S_FBRD;
					default:  state_d = S_DONE;
				endcase
			end
			S_EXEC: begin
				case (sts.cls)
					CLS_ALUF:  state_d = S_ALUX;
					CLS_DRAW:  state_d = sts.n_zero ? S_SPR_VF : S_SPR_RAM;
					CLS_BCD:   state_d = S_BCD;
					CLS_STORE: state_d = S_ST_RD;
					CLS_LOAD:  state_d = S_LD_RD;
					default:   state_d = S_DONE;
				endcase
			end
			S_ALUX:    state_d = S_DONE;
			S_SPR_RAM: state_d = S_SPR_FB;
			S_SPR_FB:  state_d = S_SPR_W0;
			S_SPR_W0:  state_d = S_SPR_W1;
			S_SPR_W1:  state_d = sts.last ? S_SPR_VF : S_SPR_RAM;
			S_SPR_VF:  state_d = S_DONE;
			S_BCD:     if (sts.last) state_d = S_DONE;
			S_ST_RD:   state_d = S_ST_WR;
			S_ST_WR:   state_d = sts.last ? S_DONE : S_ST_RD;
			S_LD_RD:   state_d = S_LD_WR;
			S_LD_WR:   state_d = sts.last ? S_DONE : S_LD_RD;
			S_FBRD:    state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.dispatch = (state_q == S_DISP);
		cmd.exec     = (state_q == S_EXEC);
		cmd.alu_wx   = (state_q == S_ALUX);
		cmd.spr_ram  = (state_q == S_SPR_RAM);
		cmd.spr_fb   = (state_q == S_SPR_FB);
		cmd.spr_w0   = (state_q == S_SPR_W0);
		cmd.spr_w1   = (state_q == S_SPR_W1);
		cmd.spr_vf   = (state_q == S_SPR_VF);
		cmd.bcd_wr   = (state_q == S_BCD);
		cmd.st_rd    = (state_q == S_ST_RD);
		cmd.st_wr    = (state_q == S_ST_WR);
		cmd.ld_rd    = (state_q == S_LD_RD);
		cmd.ld_wr    = (state_q == S_LD_WR);
		cmd.fb_done  = (state_q == S_FBRD);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vcpu_dp.sv =====
// Datapath of the execute unit: registers, stack, RAM, display and key flags.
// Depends on vcpu_pkg; driven by vcpu_ctrl commands.
`default_nettype none

module vcpu_dp import vcpu_pkg::*; #(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  wire         cfg_we,
	input  wire  [11:0] cfg_wdata,
	input  wire  [1:0]  req_type,
	input  wire  [15:0] opcode,
	input  wire  [7:0]  random_byte,
	input  wire  [3:0]  key_index,
	input  wire  [11:0] mem_addr,
	input  wire  [7:0]  mem_data,
	input  wire  [7:0]  fb_addr,
	output logic [11:0] pc_out,
	output logic        draw_flag,
	output logic [1:0]  status,
	output logic [7:0]  read_data,
	output logic [7:0]  delay_value,
	output logic [7:0]  sound_value
);

	localparam int AW  = $clog2(MEM_BYTES);
	localparam int SIW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	function automatic op_class_t decode_cls(input logic [15:0] op);
		op_class_t c;
		c = CLS_ONE;
		if (op[15:12] == GRP_DRW) begin
			c = CLS_DRAW;
		end else if (op[15:12] == GRP_ALU) begin
			if (op[3:0] == ALU_ADD || op[3:0] == ALU_SUB || op[3:0] == ALU_SHR ||
			    op[3:0] == ALU_SUBN || op[3:0] == ALU_SHL) begin
				c = CLS_ALUF;
			end
		end else if (op[15:12] == GRP_MISC) begin
			if (op[7:0] == F_BCD) c = CLS_BCD;
			else if (op[7:0] == F_STORE) c = CLS_STORE;
			else if (op[7:0] == F_LOAD) c = CLS_LOAD;
		end
		return c;
	endfunction

	// latched request
	req_t        req_q;
	logic [15:0] op_q;
	logic [7:0]  rnd_q;
	logic [3:0]  key_q;
	logic [11:0] maddr_q;
	logic [7:0]  mdata_q;
	logic [7:0]  fbaddr_q;

	// architectural state
	logic [11:0] font_q;
	logic [11:0] pc_q;
	logic [15:0] idx_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]  dly_q, snd_q;
	logic [15:0] keys_q;
	logic [11:0] stk_q [STACK_DEPTH];

	logic [7:0]  rf_mem [16];
	logic [15:0] rf_vld_q;
	logic [7:0]  rf0_q, rf1_q;

	logic [7:0]  ram_mem [MEM_BYTES];
	logic [7:0]  ram_rd_q;

	logic [7:0]  fb_mem [FB_BYTES];
	logic [FB_BYTES-1:0] fb_vld_q;
	logic [7:0]  fb0_q, fb1_q;

	// sequencing scratch
	logic [3:0]  cnt_q;
	logic        hit_q;
	logic [7:0]  res_q;
	logic [3:0]  bh_q, bt_q, bo_q;
	logic [FB_AW-1:0] idx0_q, idx1_q;
	logic [7:0]  m0_q, m1_q, nd1_q;
	logic        drew_q;
	status_t     st_q;
	logic [7:0]  rd_q;

	logic [11:0] out_pc_q;
	logic        out_drew_q;
	status_t     out_st_q;
	logic [7:0]  out_rd_q, out_dly_q, out_snd_q;

	logic [3:0]  f_x, f_y, f_n;
	logic [7:0]  f_kk, vx, vy;
	logic [11:0] f_nnn, skip;
	logic [SPW-1:0] sp_m1;
	op_class_t   cls;

	assign f_x   = op_q[11:8];
	assign f_y   = op_q[7:4];
	assign f_n   = op_q[3:0];
	assign f_kk  = op_q[7:0];
	assign f_nnn = op_q[11:0];
	assign vx    = rf0_q;
	assign vy    = rf1_q;
	assign skip  = pc_q + 12'd2;
	assign sp_m1 = sp_q - SPW'(1);
	assign cls   = decode_cls(op_q);

	always_comb begin
		sts        = '0;
		sts.req    = req_q;
		sts.cls    = cls;
		sts.n_zero = (f_n == 4'd0);
		case (cls)
			CLS_DRAW:  sts.last = (cnt_q == f_n - 4'd1);
			CLS_BCD:   sts.last = (cnt_q == 4'd2);
			CLS_STORE: sts.last = (cnt_q == f_x);
			CLS_LOAD:  sts.last = (cnt_q == f_x);
			default:   sts.last = 1'b0;
		endcase
	end

	// combinational execute decisions, committed in the execute state
	status_t     e_st;
	logic        e_vx_we, e_vf_we, e_flag, e_pc_we, e_push, e_pop;
	logic        e_idx_we, e_dly_we, e_snd_we, e_key_clr, e_cls, e_drew;
	logic [7:0]  e_vx, e_res;
	logic [11:0] e_pc;
	logic [15:0] e_idx;
	logic [8:0]  sum9;

	always_comb begin
		e_st      = ST_OK;
		e_vx_we   = 1'b0;
		e_vx      = 8'd0;
		e_vf_we   = 1'b0;
		e_flag    = 1'b0;
		e_res     = 8'd0;
		e_pc_we   = 1'b0;
		e_pc      = skip;
		e_push    = 1'b0;
		e_pop     = 1'b0;
		e_idx_we  = 1'b0;
		e_idx     = 16'd0;
		e_dly_we  = 1'b0;
		e_snd_we  = 1'b0;
		e_key_clr = 1'b0;
		e_cls     = 1'b0;
		e_drew    = 1'b0;
		sum9      = {1'b0, vx} + {1'b0, vy};
		case (op_q[15:12])
			GRP_SYS: begin
				if (op_q == OP_CLS) begin
					e_cls  = 1'b1;
					e_drew = 1'b1;
				end else if (op_q == OP_RET) begin
					if (sp_q == '0) begin
						e_st = ST_UNF;
					end else begin
						e_pop   = 1'b1;
						e_pc_we = 1'b1;
						e_pc    = stk_q[sp_m1[SIW-1:0]];
					end
				end else begin
					e_st = ST_BAD;
				end
			end
			GRP_JP: begin
				e_pc_we = 1'b1;
				e_pc    = f_nnn;
			end
			GRP_CALL: begin
				if (sp_q >= SPW'(STACK_DEPTH)) begin
					e_st = ST_OVF;
				end else begin
					e_push  = 1'b1;
					e_pc_we = 1'b1;
					e_pc    = f_nnn;
				end
			end
			GRP_SE:  e_pc_we = (vx == f_kk);
			GRP_SNE: e_pc_we = (vx != f_kk);
			GRP_SER: begin
				if (f_n != 4'd0) e_st = ST_BAD;
				else e_pc_we = (vx == vy);
			end
			GRP_LD: begin
				e_vx_we = 1'b1;
				e_vx    = f_kk;
			end
			GRP_ADD: begin
				e_vx_we = 1'b1;
				e_vx    = vx + f_kk;
			end
			GRP_ALU: begin
				case (f_n)
					ALU_MOV: begin e_vx_we = 1'b1; e_vx = vy;      end
					ALU_OR:  begin e_vx_we = 1'b1; e_vx = vx | vy; end
					ALU_AND: begin e_vx_we = 1'b1; e_vx = vx & vy; end
					ALU_XOR: begin e_vx_we = 1'b1; e_vx = vx ^ vy; end
					ALU_ADD: begin
						e_vf_we = 1'b1;
						e_flag  = sum9[8];
						e_res   = sum9[7:0];
					end
					ALU_SUB: begin
						e_vf_we = 1'b1;
						e_flag  = (vx > vy);
						e_res   = vx - vy;
					end
					ALU_SHR: begin
						e_vf_we = 1'b1;
						e_flag  = vx[0];
						e_res   = {1'b0, vx[7:1]};
					end
					ALU_SUBN: begin
						e_vf_we = 1'b1;
						e_flag  = (vy > vx);
						e_res   = vy - vx;
					end
					ALU_SHL: begin
						e_vf_we = 1'b1;
						e_flag  = vx[7];
						e_res   = {vx[6:0], 1'b0};
					end
					default: e_st = ST_BAD;
				endcase
			end
			GRP_SNER: begin
				if (f_n != 4'd0) e_st = ST_BAD;
				else e_pc_we = (vx != vy);
			end
			GRP_LDI: begin
				e_idx_we = 1'b1;
				e_idx    = {4'd0, f_nnn};
			end
			GRP_JPV: begin
				// rf0 holds V0 for this group
				e_pc_we = 1'b1;
				e_pc    = f_nnn + {4'd0, vx};
			end
			GRP_RND: begin
				e_vx_we = 1'b1;
				e_vx    = f_kk & rnd_q;
			end
			GRP_DRW: e_drew = 1'b1;
			GRP_KEY: begin
				if (f_kk == KEY_SKP) begin
					e_pc_we   = keys_q[vx[3:0]];
					e_key_clr = keys_q[vx[3:0]];
				end else if (f_kk == KEY_SKNP) begin
					e_pc_we   = !keys_q[vx[3:0]];
					e_key_clr = keys_q[vx[3:0]];
				end else begin
					e_st = ST_BAD;
				end
			end
			GRP_MISC: begin
				case (f_kk)
					F_GETDT: begin e_vx_we = 1'b1; e_vx = dly_q; end
					F_SETDT: e_dly_we = 1'b1;
					F_SETST: e_snd_we = 1'b1;
					F_ADDI: begin
						e_idx_we = 1'b1;
						e_idx    = idx_q + {8'd0, vx};
					end
					F_FONT: begin
						e_idx_we = 1'b1;
						e_idx    = 16'(font_q) + 16'({vx[3:0], 2'b00}) + 16'(vx[3:0]);
					end
					F_BCD, F_STORE, F_LOAD: ;
					default: e_st = ST_BAD;
				endcase
			end
			default: e_st = ST_BAD;
		endcase
	end

	// decimal digits of vx: compare for hundreds, reciprocal multiply for tens
	logic [1:0]  bh;
	logic [7:0]  brem;
	logic [14:0] bprod;
	logic [3:0]  bt;
	logic [6:0]  bten, bdiff;

	always_comb begin
		if (vx >= 8'd200) begin
			bh   = 2'd2;
			brem = vx - 8'd200;
		end else if (vx >= 8'd100) begin
			bh   = 2'd1;
			brem = vx - 8'd100;
		end else begin
			bh   = 2'd0;
			brem = vx;
		end
		bprod = 15'(brem[6:0]) * 15'd205;
		bt    = bprod[14:11];
		bten  = 7'({bt, 3'b000}) + 7'({bt, 1'b0});
		bdiff = brem[6:0] - bten;
	end

	// sprite row geometry
	logic [ROW_W-1:0] spr_y;
	logic [2:0]       spr_col, spr_col1;
	logic [15:0]      spr_sh;
	logic [FB_AW-1:0] spr_i0, spr_i1;

	always_comb begin
		spr_y    = vy[ROW_W-1:0] + ROW_W'(cnt_q);
		spr_col  = vx[5:3];
		spr_col1 = spr_col + 3'd1;
		spr_sh   = {ram_rd_q, 8'h00} >> vx[2:0];
		spr_i0   = {spr_y, spr_col};
		spr_i1   = {spr_y, spr_col1};
	end

	// RAM address from I plus the step counter
	logic [15:0]   isum;
	logic [AW-1:0] iaddr;
	assign isum  = idx_q + {12'd0, cnt_q};
	assign iaddr = isum[AW-1:0];

	// register file port muxing
	logic [3:0] rf_a0;
	logic       rf_re;
	logic       rf_we;
	logic [3:0] rf_wa;
	logic [7:0] rf_wd;

	always_comb begin
		rf_re = cmd.dispatch || cmd.st_rd;
		rf_a0 = cmd.st_rd ? cnt_q : ((op_q[15:12] == GRP_JPV) ? 4'd0 : f_x);
		rf_we = 1'b0;
		rf_wa = f_x;
		rf_wd = e_vx;
		if (cmd.exec && e_vx_we) begin
			rf_we = 1'b1;
		end else if (cmd.exec && e_vf_we) begin
			rf_we = 1'b1;
			rf_wa = 4'hF;
			rf_wd = {7'd0, e_flag};
		end else if (cmd.alu_wx) begin
			rf_we = 1'b1;
			rf_wd = res_q;
		end else if (cmd.spr_vf) begin
			rf_we = 1'b1;
			rf_wa = 4'hF;
			rf_wd = {7'd0, hit_q};
		end else if (cmd.ld_wr) begin
			rf_we = 1'b1;
			rf_wa = cnt_q;
			rf_wd = ram_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		if (rf_re) begin
			rf0_q <= rf_vld_q[rf_a0] ? rf_mem[rf_a0] : 8'd0;
			rf1_q <= rf_vld_q[f_y] ? rf_mem[f_y] : 8'd0;
		end
	end

	// RAM port muxing
	logic          ram_we;
	logic [AW-1:0] ram_wa;
	logic [7:0]    ram_wd;
	logic [7:0]    bcd_digit;

	always_comb begin
		case (cnt_q)
			4'd0:    bcd_digit = {4'd0, bh_q};
			4'd1:    bcd_digit = {4'd0, bt_q};
			default: bcd_digit = {4'd0, bo_q};
		endcase
		ram_we = 1'b0;
		ram_wa = iaddr;
		ram_wd = rf0_q;
		if (cmd.dispatch && req_q == REQ_MEMWR) begin
			ram_we = 1'b1;
			ram_wa = maddr_q[AW-1:0];
			ram_wd = mdata_q;
		end else if (cmd.bcd_wr) begin
			ram_we = 1'b1;
			ram_wd = bcd_digit;
		end else if (cmd.st_wr) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_wa] <= ram_wd;
		if (cmd.spr_ram || cmd.ld_rd) ram_rd_q <= ram_mem[iaddr];
	end

	// display port muxing
	logic             fb_re;
	logic [FB_AW-1:0] fb_a0;
	logic             fb_we;
	logic [FB_AW-1:0] fb_wa;
	logic [7:0]       fb_wd;

	always_comb begin
		fb_re = cmd.spr_fb || (cmd.dispatch && req_q == REQ_FBRD);
		fb_a0 = cmd.spr_fb ? spr_i0 : fbaddr_q[FB_AW-1:0];
		fb_we = cmd.spr_w0 || cmd.spr_w1;
		fb_wa = cmd.spr_w1 ? idx1_q : idx0_q;
		fb_wd = cmd.spr_w1 ? nd1_q : (fb0_q ^ m0_q);
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_wa] <= fb_wd;
		if (fb_re) begin
			fb0_q <= fb_vld_q[fb_a0] ? fb_mem[fb_a0] : 8'd0;
			fb1_q <= fb_vld_q[spr_i1] ? fb_mem[spr_i1] : 8'd0;
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= req_t'(req_type);
			op_q     <= opcode;
			rnd_q    <= random_byte;
			key_q    <= key_index;
			maddr_q  <= mem_addr;
			mdata_q  <= mem_data;
			fbaddr_q <= fb_addr;
		end
		if (cmd.exec) begin
			res_q <= e_res;
			bh_q  <= {2'd0, bh};
			bt_q  <= bt;
			bo_q  <= bdiff[3:0];
		end
		if (cmd.spr_fb) begin
			idx0_q <= spr_i0;
			idx1_q <= spr_i1;
			m0_q   <= spr_sh[15:8];
			m1_q   <= spr_sh[7:0];
		end
		if (cmd.spr_w0) nd1_q <= fb1_q ^ m1_q;
		if (cmd.exec && e_push) stk_q[sp_q[SIW-1:0]] <= pc_q;
		if (cmd.out_load) begin
			out_pc_q   <= pc_q;
			out_drew_q <= drew_q;
			out_st_q   <= st_q;
			out_rd_q   <= rd_q;
			out_dly_q  <= dly_q;
			out_snd_q  <= snd_q;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q   <= FONT_RESET;
			pc_q     <= PC_RESET;
			idx_q    <= 16'd0;
			sp_q     <= '0;
			dly_q    <= 8'd0;
			snd_q    <= 8'd0;
			keys_q   <= 16'd0;
			rf_vld_q <= 16'd0;
			fb_vld_q <= '0;
			cnt_q    <= 4'd0;
			hit_q    <= 1'b0;
			drew_q   <= 1'b0;
			st_q     <= ST_OK;
			rd_q     <= 8'd0;
		end else begin
			if (cfg_we) font_q <= cfg_wdata;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
			if (cmd.dispatch) begin
				drew_q <= 1'b0;
				st_q   <= ST_OK;
				rd_q   <= 8'd0;
				if (req_q == REQ_EXEC) pc_q <= pc_q + 12'd2;
				if (req_q == REQ_KEY) keys_q[key_q] <= 1'b1;
			end
			if (cmd.exec) begin
				drew_q <= e_drew;
				st_q   <= e_st;
				cnt_q  <= 4'd0;
				hit_q  <= 1'b0;
				if (e_pc_we) pc_q <= e_pc;
				if (e_push) sp_q <= sp_q + SPW'(1);
				if (e_pop) sp_q <= sp_m1;
				if (e_idx_we) idx_q <= e_idx;
				if (e_dly_we) dly_q <= vx;
				if (e_snd_we) snd_q <= vx;
				if (e_key_clr) keys_q[vx[3:0]] <= 1'b0;
				if (e_cls) fb_vld_q <= '0;
			end
			if (fb_we) fb_vld_q[fb_wa] <= 1'b1;
			if (cmd.spr_w0) hit_q <= hit_q | (|((fb0_q & m0_q) | (fb1_q & m1_q)));
			if (cmd.spr_w1 || cmd.bcd_wr || cmd.st_wr || cmd.ld_wr) cnt_q <= cnt_q + 4'd1;
			if (cmd.fb_done) rd_q <= fb0_q;
		end
	end

	assign pc_out      = out_pc_q;
	assign draw_flag   = out_drew_q;
	assign status      = out_st_q;
	assign read_data   = out_rd_q;
	assign delay_value = out_dly_q;
	assign sound_value = out_snd_q;

endmodule

`default_nettype wire

// ===== rtl/virtual_cpu_execute_unit_top.sv =====
// Top level of the virtual CPU execute unit.
// Depends on vcpu_pkg, vcpu_ctrl and vcpu_dp.
//
// Usage:
//  - Input channel (in_valid / in_stall): one request per transfer. req_type
//    selects execute opcode, key press, RAM byte write or display byte read.
//  - Output channel (out_valid / out_stall): exactly one result per request,
//    in order. The result sits in an output register and holds while stalled.
//  - cfg_we / cfg_wdata write font_base; write only while the unit is idle.
//  - One request is in flight at a time; in_stall is high from the transfer
//    until the result is loaded into the output register.
//  - Steps: dispatch, then the result for key and RAM write; display read
//    and most opcodes add a read or execute step; flag-setting ALU ops add
//    a write-back; BCD writes three digits; store/load moves each of V0..Vx.
//    Each sprite row is a RAM read, a display read and two display writes.
//  - A new request can be taken as soon as the previous result is in the
//    output register, even if the receiver is still stalling it; a full
//    output register holds the unit in its final state until it drains.
//  - Reset: PC 0x200, registers, index, stack pointer, timers, keys and
//    display clear at once; RAM and the return stack hold no reset value.
`default_nettype none

module virtual_cpu_execute_unit_top import vcpu_pkg::*; #(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [11:0] cfg_wdata,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  req_type,
	input  wire  [15:0] opcode,
	input  wire  [7:0]  random_byte,
	input  wire  [3:0]  key_index,
	input  wire  [11:0] mem_addr,
	input  wire  [7:0]  mem_data,
	input  wire  [7:0]  fb_addr,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [11:0] pc_out,
	output logic        draw_flag,
	output logic [1:0]  status,
	output logic [7:0]  read_data,
	output logic [7:0]  delay_value,
	output logic [7:0]  sound_value
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: one state per datapath step
	vcpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// all storage and arithmetic
	vcpu_dp #(
		.MEM_BYTES   (MEM_BYTES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.opcode      (opcode),
		.random_byte (random_byte),
		.key_index   (key_index),
		.mem_addr    (mem_addr),
		.mem_data    (mem_data),
		.fb_addr     (fb_addr),
		.pc_out      (pc_out),
		.draw_flag   (draw_flag),
		.status      (status),
		.read_data   (read_data),
		.delay_value (delay_value),
		.sound_value (sound_value)
	);

endmodule

`default_nettype wire

// ===== rtl/vcpu_chk.sv =====
// Port-level checker for the execute unit, bound to the top level.
// Depends on vcpu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vcpu_chk import vcpu_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [11:0] pc_out,
	input wire        draw_flag,
	input wire [1:0]  status,
	input wire [7:0]  read_data
);

	`VCPU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`VCPU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pc_out) && $stable(read_data), "result changed while stalled")
	`VCPU_ASSERT(a_draw_ok, (out_valid && draw_flag) |-> (status == ST_OK && read_data == 8'd0), "draw with error or read data")
	`VCPU_ASSERT(a_err_no_rd, (out_valid && status != ST_OK) |-> (read_data == 8'd0), "error result carries read data")

endmodule

bind virtual_cpu_execute_unit_top vcpu_chk u_vcpu_chk (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for virtual_cpu_execute_unit_top: random and directed CHIP-8 requests.
// Depends on vcpu_pkg and the execute unit RTL; holds its own behavioral copy of the CPU.
`default_nettype none

module tb_top;
	import vcpu_pkg::*;

	localparam int MEM_SIZE   = 4096;
	localparam int STACK_SIZE = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		req_t        kind;
		logic [15:0] op;
		logic [7:0]  rnd;
		logic [3:0]  key;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [7:0]  fbi;
	} cpu_req_t;

	typedef struct {
		logic [11:0] pc;
		logic        drew;
		status_t     st;
		logic [7:0]  rd;
		logic [7:0]  dly;
		logic [7:0]  snd;
	} cpu_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [11:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [15:0] opcode = '0;
	logic [7:0]  random_byte = '0;
	logic [3:0]  key_index = '0;
	logic [11:0] mem_addr = '0;
	logic [7:0]  mem_data = '0;
	logic [7:0]  fb_addr = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] pc_out;
	logic        draw_flag;
	logic [1:0]  status;
	logic [7:0]  read_data;
	logic [7:0]  delay_value;
	logic [7:0]  sound_value;

	// Mirror of the architectural state
	logic [7:0]  vreg [16];
	logic [15:0] ireg;
	logic [11:0] pc;
	logic [11:0] rstack [STACK_SIZE];
	int          sp;
	logic [7:0]  dly, snd;
	logic [7:0]  mem [MEM_SIZE];
	bit          written [MEM_SIZE];
	logic [7:0]  screen [FB_BYTES];
	logic        keys [16];
	logic [11:0] font;

	cpu_req_t  req_q [$];
	cpu_resp_t resp_q [$];
	cpu_req_t  cur;
	bit        taken;
	int        send_idle_pct, stall_pct;
	int        mismatches, n_req, n_resp, n_draw, n_ovf, n_unf, n_bad, quiet;

	virtual_cpu_execute_unit_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .opcode(opcode),
		.random_byte(random_byte), .key_index(key_index), .mem_addr(mem_addr),
		.mem_data(mem_data), .fb_addr(fb_addr), .out_valid(out_valid),
		.out_stall(out_stall), .pc_out(pc_out), .draw_flag(draw_flag), .status(status),
		.read_data(read_data), .delay_value(delay_value), .sound_value(sound_value)
	);

	always #5 clk = ~clk;

	// XOR a sprite into the screen mirror; returns 1 on a collision
	function automatic bit blit(logic [7:0] x0, logic [7:0] y0, int rows);
		bit   hit;
		int   x, y, idx;
		logic [7:0] line, mask;
		hit = 0;
		for (int r = 0; r < rows; r++) begin
			line = mem[(ireg + r) % MEM_SIZE];
			y = (y0 + r) % SCREEN_ROWS;
			for (int c = 0; c < 8; c++) begin
				x = (x0 + c) & 63;
				idx = y * 8 + (x >> 3);
				mask = 8'h80 >> (x & 7);
				if (line[7 - c]) begin
					if (screen[idx] & mask)
						hit = 1;
					screen[idx] ^= mask;
				end
			end
		end
		return hit;
	endfunction

	// Execute one opcode against the mirror; pc already advanced
	function automatic status_t run_opcode(logic [15:0] op, logic [7:0] rnd, ref logic drew);
		logic [3:0]  g, x, y, n;
		logic [7:0]  kk, vx, vy;
		logic [11:0] nnn, skip;
		logic [8:0]  sum;
		g = op[15:12]; x = op[11:8]; y = op[7:4]; n = op[3:0];
		kk = op[7:0]; nnn = op[11:0];
		vx = vreg[x]; vy = vreg[y];
		skip = pc + 12'd2;
		case (g)
		GRP_SYS: begin
			if (op == OP_CLS) begin
				foreach (screen[i]) screen[i] = '0;
				drew = 1;
			end else if (op == OP_RET) begin
				if (sp == 0)
					return ST_UNF;
				sp--;
				pc = rstack[sp];
			end else
				return ST_BAD;
		end
		GRP_JP: pc = nnn;
		GRP_CALL: begin
			if (sp >= STACK_SIZE)
				return ST_OVF;
			rstack[sp] = pc;
			sp++;
			pc = nnn;
		end
		GRP_SE:  if (vx == kk) pc = skip;
		GRP_SNE: if (vx != kk) pc = skip;
		GRP_SER: begin
			if (n != 0)
				return ST_BAD;
			if (vx == vy) pc = skip;
		end
		GRP_LD:  vreg[x] = kk;
		GRP_ADD: vreg[x] = vx + kk;
		GRP_ALU: begin
			// VF goes first, so x == F keeps the result
			case (n)
			ALU_MOV: vreg[x] = vy;
			ALU_OR:  vreg[x] = vx | vy;
			ALU_AND: vreg[x] = vx & vy;
			ALU_XOR: vreg[x] = vx ^ vy;
			ALU_ADD: begin
				sum = vx + vy;
				vreg[15] = {7'd0, sum[8]};
				vreg[x] = sum[7:0];
			end
			ALU_SUB: begin
				vreg[15] = {7'd0, vx > vy};
				vreg[x] = vx - vy;
			end
			ALU_SHR: begin
				vreg[15] = {7'd0, vx[0]};
				vreg[x] = vx >> 1;
			end
			ALU_SUBN: begin
				vreg[15] = {7'd0, vy > vx};
				vreg[x] = vy - vx;
			end
			ALU_SHL: begin
				vreg[15] = {7'd0, vx[7]};
				vreg[x] = vx << 1;
			end
			default: return ST_BAD;
			endcase
		end
		GRP_SNER: begin
			if (n != 0)
				return ST_BAD;
			if (vx != vy) pc = skip;
		end
		GRP_LDI: ireg = {4'd0, nnn};
		GRP_JPV: pc = nnn + vreg[0];
		GRP_RND: vreg[x] = kk & rnd;
		GRP_DRW: begin
			vreg[15] = {7'd0, blit(vx, vy, n)};
			drew = 1;
		end
		GRP_KEY: begin
			// a key found pressed is consumed
			if (kk == KEY_SKP) begin
				if (keys[vx[3:0]]) begin
					pc = skip;
					keys[vx[3:0]] = 0;
				end
			end else if (kk == KEY_SKNP) begin
				if (!keys[vx[3:0]])
					pc = skip;
				else
					keys[vx[3:0]] = 0;
			end else
				return ST_BAD;
		end
		default: begin
			case (kk)
			F_GETDT: vreg[x] = dly;
			F_SETDT: dly = vx;
			F_SETST: snd = vx;
			F_ADDI:  ireg = ireg + vx;
			F_FONT:  ireg = font + 16'd5 * vx[3:0];
			F_BCD: begin
				mem[ireg % MEM_SIZE] = vx / 100;
				mem[(ireg + 1) % MEM_SIZE] = (vx / 10) % 10;
				mem[(ireg + 2) % MEM_SIZE] = vx % 10;
				for (int i = 0; i < 3; i++) written[(ireg + i) % MEM_SIZE] = 1;
			end
			F_STORE: begin
				for (int i = 0; i <= x; i++) begin
					mem[(ireg + i) % MEM_SIZE] = vreg[i];
					written[(ireg + i) % MEM_SIZE] = 1;
				end
			end
			F_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = mem[(ireg + i) % MEM_SIZE];
			default: return ST_BAD;
			endcase
		end
		endcase
		return ST_OK;
	endfunction

	function automatic cpu_resp_t apply_request(cpu_req_t r);
		cpu_resp_t e;
		logic drew;
		drew = 0;
		e.st = ST_OK;
		e.rd = '0;
		case (r.kind)
		REQ_EXEC: begin
			pc = pc + 12'd2;
			e.st = run_opcode(r.op, r.rnd, drew);
		end
		REQ_KEY:   keys[r.key] = 1;
		REQ_MEMWR: begin
			mem[r.addr] = r.data;
			written[r.addr] = 1;
		end
		default:   e.rd = screen[r.fbi];
		endcase
		e.pc = pc; e.drew = drew; e.dly = dly; e.snd = snd;
		return e;
	endfunction

	// True when the request would read a RAM byte that was never written
	function automatic bit reads_unwritten(cpu_req_t r);
		int cnt;
		cnt = 0;
		if (r.kind == REQ_EXEC && r.op[15:12] == GRP_DRW)
			cnt = r.op[3:0];
		else if (r.kind == REQ_EXEC && r.op[15:12] == GRP_MISC && r.op[7:0] == F_LOAD)
			cnt = r.op[11:8] + 1;
		for (int i = 0; i < cnt; i++)
			if (!written[(ireg + i) % MEM_SIZE])
				return 1;
		return 0;
	endfunction

	function automatic cpu_req_t rand_fields();
		cpu_req_t r;
		r.kind = REQ_EXEC;
		r.op = $urandom; r.rnd = $urandom; r.key = $urandom;
		r.addr = $urandom; r.data = $urandom; r.fbi = $urandom;
		return r;
	endfunction

	// Mostly well-formed opcodes, with stray encodings mixed in
	function automatic logic [15:0] rand_opcode();
		logic [15:0] op;
		logic [7:0] f_ops [8] = '{F_GETDT, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD,
			F_STORE, F_LOAD};
		logic [3:0] alu_ops [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
			ALU_SHR, ALU_SUBN, ALU_SHL};
		bit wellformed;
		op = $urandom;
		wellformed = $urandom_range(9) != 0;
		case (op[15:12])
		GRP_SYS: if (wellformed) op = $urandom_range(2) == 0 ? OP_CLS : OP_RET;
		GRP_SER, GRP_SNER: if (wellformed) op[3:0] = 4'h0;
		GRP_ALU: if (wellformed) op[3:0] = alu_ops[$urandom_range(8)];
		GRP_KEY: if (wellformed) op[7:0] = $urandom_range(1) ? KEY_SKP : KEY_SKNP;
		GRP_MISC: if (wellformed) op[7:0] = f_ops[$urandom_range(7)];
		default: ;
		endcase
		return op;
	endfunction

	task automatic push_op(logic [15:0] op);
		cpu_req_t r;
		r = rand_fields();
		r.op = op;
		req_q.push_back(r);
	endtask

	task automatic push_other(req_t k, logic [11:0] a, logic [7:0] d);
		cpu_req_t r;
		r = rand_fields();
		r.kind = k;
		r.key = a[3:0]; r.addr = a; r.fbi = a[7:0]; r.data = d;
		req_q.push_back(r);
	endtask

	task automatic add_random(int count);
		cpu_req_t r;
		int pick;
		repeat (count) begin
			r = rand_fields();
			pick = $urandom_range(99);
			if (pick < 60) begin
				r.kind = REQ_EXEC;
				r.op = rand_opcode();
			end else if (pick < 75)
				r.kind = REQ_KEY;
			else if (pick < 85)
				r.kind = REQ_MEMWR;
			else
				r.kind = REQ_FBRD;
			req_q.push_back(r);
		end
	endtask

	// Unit must be idle: queue drained and every result back
	task automatic drain();
		do @(negedge clk); while (req_q.size() != 0 || in_valid || resp_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_font(logic [11:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		font = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: new transfer offered at the falling edge once the last one went
	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= $urandom_range(99) < stall_pct;
			if (!in_valid || taken) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur = req_q.pop_front();
					// a read of unwritten RAM becomes a full block store at I
					if (reads_unwritten(cur))
						cur.op = {GRP_MISC, 4'hF, F_STORE};
					in_valid <= 1'b1;
					req_type <= cur.kind;
					opcode <= cur.op;
					random_byte <= cur.rnd;
					key_index <= cur.key;
					mem_addr <= cur.addr;
					mem_data <= cur.data;
					fb_addr <= cur.fbi;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Input side: predict on every accepted request
	always @(posedge clk) begin
		taken = arst_n && in_valid && !in_stall;
		if (taken) begin
			resp_q.push_back(apply_request(cur));
			n_req++;
		end
	end

	// Monitor: results compared in order with the predicted queue
	always @(posedge clk) begin
		cpu_resp_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_resp++;
			if (resp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result pc=%h status=%0d", pc_out, status);
			end else begin
				e = resp_q.pop_front();
				if (e.drew) n_draw++;
				if (e.st == ST_OVF) n_ovf++;
				if (e.st == ST_UNF) n_unf++;
				if (e.st == ST_BAD) n_bad++;
				if (pc_out !== e.pc || draw_flag !== e.drew || status !== e.st ||
						read_data !== e.rd || delay_value !== e.dly ||
						sound_value !== e.snd) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: result %0d exp pc=%h draw=%b st=%0d rd=%h dt=%h ",
							"st=%h got pc=%h draw=%b st=%0d rd=%h dt=%h st=%h"},
							n_resp, e.pc, e.drew, e.st, e.rd, e.dly, e.snd, pc_out,
							draw_flag, status, read_data, delay_value, sound_value);
				end
			end
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else if (arst_n && ++quiet >= STALL_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int phase_idle [4] = '{0, 79, 0, 13};
		int phase_stall [4] = '{0, 0, 79, 13};
		logic [11:0] phase_font [4];
		mismatches = 0; n_req = 0; n_resp = 0; n_draw = 0;
		n_ovf = 0; n_unf = 0; n_bad = 0; quiet = 0;
		send_idle_pct = 0; stall_pct = 0; taken = 0;
		foreach (vreg[i]) vreg[i] = '0;
		foreach (keys[i]) keys[i] = 0;
		foreach (screen[i]) screen[i] = '0;
		foreach (mem[i]) mem[i] = '0;
		foreach (written[i]) written[i] = 0;
		ireg = '0; pc = PC_RESET; sp = 0; dly = '0; snd = '0; font = FONT_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corner cases
		for (int a = 0; a < 16; a++)
			push_other(REQ_MEMWR, 12'(a), 8'($urandom));  // sprite rows at I = 0
		push_op(OP_RET);                       // return on empty stack
		push_op(16'h2ABC); push_op(OP_RET);    // call then return
		push_op(16'h603C); push_op(16'h611E);  // V0=60, V1=30
		push_op(16'hA000); push_op(16'hD01F);  // sprite wraps both axes
		push_op(16'hD01F);                     // same sprite again: collision
		push_other(REQ_FBRD, 12'h0FF, 8'h00);
		push_other(REQ_FBRD, 12'h000, 8'h00);
		push_op(16'h62FF); push_op(16'h8224);  // add with carry
		push_op(16'h8F25); push_op(16'h8F27);  // subtracts into VF
		push_op(16'h8F0E); push_op(16'h8F06);  // shifts with x = F
		push_op(16'hAFFF); push_op(16'hF233);  // BCD of 254 wrapping RAM
		push_op(16'hFF55); push_op(16'hFF65);  // full register block
		push_other(REQ_KEY, 12'h00F, 8'h00);
		push_op(16'h6E0F); push_op(16'hEE9E); push_op(16'hEEA1);
		push_op(16'hFE29); push_op(16'hF00A);  // font address, unsupported key wait
		push_op(16'h5121); push_op(16'h0123); push_op(16'hBFFF); push_op(OP_CLS);
		push_other(REQ_MEMWR, 12'hFFF, 8'hFF);
		push_op(16'hFF15); push_op(16'hFF18); push_op(16'hF107);

		phase_font[0] = 12'd0;
		phase_font[1] = 12'hFFF;
		phase_font[2] = $urandom;
		phase_font[3] = FONT_RESET;
		for (int p = 0; p < 4; p++) begin
			drain();
			write_font(phase_font[p]);
			send_idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			add_random(p == 0 ? 500 : 450);
		end
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
		$display("Covered %0d requests, %0d draws/clears, %0d bad opcodes,",
			n_req, n_draw, n_bad);
		$display("%0d stack overflows, %0d underflows, font base 0 / max / random / default",
			n_ovf, n_unf);
		if (mismatches == 0 && resp_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else begin
			$display("%0d mismatches, %0d results missing", mismatches, resp_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
